// ----- rtl/mcpl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the motor current power limiter.
// No dependencies; used by the core.
package mcpl_pkg;

	// Motor count, fixed by the request and result layouts below
	localparam int NUM_MOTORS = 4;

	// Field widths
	localparam int CMD_W    = 16;
	localparam int POWER_W  = 16;
	localparam int BUDGET_W = 18;
	localparam int RATIO_W  = 16;
	localparam int SUM_W    = $clog2(NUM_MOTORS * 32768 + 1);
	localparam int PROD_W   = CMD_W + BUDGET_W;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = BUDGET_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIMIT_ENABLE   = 2'd0,
		REG_WARNING_POWER  = 2'd1,
		REG_POWER_CEILING  = 2'd2,
		REG_FULL_BUDGET    = 2'd3
	} cfg_reg_t;

	// Register reset values
	localparam logic                LIMIT_ENABLE_RST = 1'b1;
	localparam logic [POWER_W-1:0]  WARNING_RST      = 16'd960;
	localparam logic [POWER_W-1:0]  CEILING_RST      = 16'd1280;
	localparam logic [BUDGET_W-1:0] FULL_BUDGET_RST  = 18'd64000;

	// Pipeline depth: input stage, ratio divider, budget multiply, budget select,
	// command multiply, command divider, output stage
	localparam int RATIO_Q_W = RATIO_W;
	localparam int CMD_Q_W   = CMD_W;
	localparam int LATENCY   = 1 + RATIO_Q_W + 3 + CMD_Q_W + 1;

	typedef struct packed {
		logic        [POWER_W-1:0] measured_power;
		logic signed [CMD_W-1:0]   motor_cmd_0;
		logic signed [CMD_W-1:0]   motor_cmd_1;
		logic signed [CMD_W-1:0]   motor_cmd_2;
		logic signed [CMD_W-1:0]   motor_cmd_3;
	} req_t;

	typedef struct packed {
		logic signed [CMD_W-1:0] limited_cmd_0;
		logic signed [CMD_W-1:0] limited_cmd_1;
		logic signed [CMD_W-1:0] limited_cmd_2;
		logic signed [CMD_W-1:0] limited_cmd_3;
	} res_t;

endpackage

// ----- rtl/mcpl_div_pipe.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; instanced by the limiter core.
module mcpl_div_pipe #(
	parameter int DW = 16,
	parameter int QW = 16
) (
	input  logic          clk,
	input  logic [DW-1:0] rem_init,
	input  logic [QW-1:0] num_low,
	input  logic [DW-1:0] divisor,
	output logic [QW-1:0] quotient
);
	// Numerator is {rem_init, num_low}; rem_init must be below the divisor,
	// so the quotient fits QW bits.
	logic [DW-1:0] rem_s [0:QW-1];
	logic [DW-1:0] dvs_s [0:QW-1];
	logic [QW-1:0] low_s [0:QW-1];
	logic [QW-1:0] quo_s [0:QW];

	assign rem_s[0] = rem_init;
	assign dvs_s[0] = divisor;
	assign low_s[0] = num_low;
	assign quo_s[0] = '0;

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW:0] trial;
		logic        ge;

		// Shift in the next numerator bit and try to subtract
		always_comb begin
			trial = {rem_s[k], low_s[k][QW-1]};
			ge    = (trial >= {1'b0, dvs_s[k]});
		end

		always_ff @(posedge clk) begin
			quo_s[k+1] <= {quo_s[k][QW-2:0], ge};
		end

		// Advance remainder, divisor and remaining numerator bits
		if (k < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[k+1] <= ge ? DW'(trial - {1'b0, dvs_s[k]}) : trial[DW-1:0];
				dvs_s[k+1] <= dvs_s[k];
				low_s[k+1] <= low_s[k] << 1;
			end
		end
	end

	assign quotient = quo_s[QW];

endmodule

// ----- rtl/motor_current_power_limiter_core.sv -----
`timescale 1ns / 1ps
// Top level of the motor current power limiter: registers, pipeline, dividers.
// Depends on mcpl_pkg and mcpl_div_pipe.

// Usage: the block takes one request per clock cycle and busy is always low.
// Each request gives one result after it passes the whole pipeline, shown
// for one cycle with done high; the receiver cannot hold it off, so it must
// take it in that cycle. The pipeline is made of the two pipelined dividers of
// 16 stages each (budget ratio, then per-motor scaling) plus five stages for
// input, budget multiply, budget select, command multiply and output.
// Configuration writes take effect at once and belong only to idle periods.
module motor_current_power_limiter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  mcpl_pkg::req_t                      request,
	output logic                                done,
	output mcpl_pkg::res_t                      result,
	input  logic                                cfg_wen,
	input  logic [mcpl_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [mcpl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import mcpl_pkg::*;

	typedef enum logic [1:0] {
		BSEL_FULL  = 2'd0,
		BSEL_ZERO  = 2'd1,
		BSEL_RATIO = 2'd2
	} budget_sel_t;

	typedef struct packed {
		logic [NUM_MOTORS-1:0][CMD_W-1:0] cmd;
		logic [NUM_MOTORS-1:0][CMD_W-1:0] mag;
		logic [SUM_W-1:0]                 sum;
		budget_sel_t                      bsel;
	} ctx_a_t;

	typedef struct packed {
		logic [NUM_MOTORS-1:0][CMD_W-1:0] cmd;
		logic                             scale;
	} ctx_b_t;

	localparam int ST_RATIO  = 1 + RATIO_Q_W;
	localparam int ST_BRAW   = ST_RATIO + 1;
	localparam int ST_BUDGET = ST_BRAW + 1;
	localparam int ST_PROD   = ST_BUDGET + 1;
	localparam int ST_QUOT   = ST_PROD + CMD_Q_W;
	localparam int CMP_W     = SUM_W + BUDGET_W;

	// Configuration registers
	logic                limit_en_q;
	logic [POWER_W-1:0]  warning_q;
	logic [POWER_W-1:0]  ceiling_q;
	logic [BUDGET_W-1:0] full_budget_q;

	// Pipeline state
	logic [LATENCY:1]    valid_s;
	ctx_a_t              ctx_a_s [1:ST_BUDGET];
	ctx_b_t              ctx_b_s [ST_PROD:ST_QUOT];
	logic [POWER_W-1:0]  num_s1;
	logic [POWER_W-1:0]  den_s1;
	logic [BUDGET_W-1:0] budget_raw_s18;
	logic [BUDGET_W-1:0] budget_s19;
	logic                scale_s19;
	logic [PROD_W-1:0]   prod_s20 [NUM_MOTORS];
	logic [SUM_W-1:0]    sum_s20;
	res_t                result_s37;

	logic [RATIO_Q_W-1:0]       ratio;
	logic [CMD_Q_W-1:0]         quot [NUM_MOTORS];
	logic [NUM_MOTORS-1:0][CMD_W-1:0] cmd_c;
	ctx_a_t                     ctx_c;
	logic [PROD_W-1:0]          bmul_c;
	logic [BUDGET_W-1:0]        budget_c;
	logic [CMD_W-1:0]           out_c [NUM_MOTORS];
	logic                       accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_en_q    <= LIMIT_ENABLE_RST;
			warning_q     <= WARNING_RST;
			ceiling_q     <= CEILING_RST;
			full_budget_q <= FULL_BUDGET_RST;
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_idx))
				REG_LIMIT_ENABLE:  limit_en_q    <= cfg_wdata[0];
				REG_WARNING_POWER: warning_q     <= cfg_wdata[POWER_W-1:0];
				REG_POWER_CEILING: ceiling_q     <= cfg_wdata[POWER_W-1:0];
				REG_FULL_BUDGET:   full_budget_q <= cfg_wdata[BUDGET_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			valid_s <= {valid_s[LATENCY-1:1], accept};
		end
	end

	// Stage 1: magnitudes, their sum and the budget case
	assign cmd_c[0] = request.motor_cmd_0;
	assign cmd_c[1] = request.motor_cmd_1;
	assign cmd_c[2] = request.motor_cmd_2;
	assign cmd_c[3] = request.motor_cmd_3;

	always_comb begin
		ctx_c.cmd = cmd_c;
		ctx_c.sum = '0;
		for (int i = 0; i < NUM_MOTORS; i++) begin
			ctx_c.mag[i] = cmd_c[i][CMD_W-1] ? CMD_W'(-cmd_c[i]) : cmd_c[i];
			ctx_c.sum    = ctx_c.sum + SUM_W'(ctx_c.mag[i]);
		end
		if (request.measured_power <= warning_q) begin
			ctx_c.bsel = BSEL_FULL;
		end else if (request.measured_power >= ceiling_q) begin
			ctx_c.bsel = BSEL_ZERO;
		end else begin
			ctx_c.bsel = BSEL_RATIO;
		end
	end

	always_ff @(posedge clk) begin
		ctx_a_s[1] <= ctx_c;
		num_s1     <= ceiling_q - request.measured_power;
		den_s1     <= ceiling_q - warning_q;
	end

	// Ratio = ((ceiling - power) << 16) / (ceiling - warning), stages 2..17
	mcpl_div_pipe #(
		.DW (POWER_W),
		.QW (RATIO_Q_W)
	) u_ratio_div (
		.clk      (clk),
		.rem_init (num_s1),
		.num_low  ('0),
		.divisor  (den_s1),
		.quotient (ratio)
	);

	// Hold the request context alongside the ratio divider and budget stages
	always_ff @(posedge clk) begin
		for (int k = 2; k <= ST_BUDGET; k++) begin
			ctx_a_s[k] <= ctx_a_s[k-1];
		end
	end

	// Stage 18: scale the full budget by the ratio
	assign bmul_c = PROD_W'(full_budget_q) * PROD_W'(ratio);

	always_ff @(posedge clk) begin
		budget_raw_s18 <= bmul_c[PROD_W-1:PROD_W-BUDGET_W];
	end

	// Stage 19: pick the budget and decide whether to scale
	always_comb begin
		case (ctx_a_s[ST_BRAW].bsel)
			BSEL_FULL:  budget_c = full_budget_q;
			BSEL_ZERO:  budget_c = '0;
			BSEL_RATIO: budget_c = budget_raw_s18;
			default:    budget_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		budget_s19 <= budget_c;
		scale_s19  <= limit_en_q &&
			(CMP_W'(ctx_a_s[ST_BRAW].sum) > CMP_W'(budget_c));
	end

	// Stage 20: magnitude times budget per motor, carry the sum as divisor
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_MOTORS; i++) begin
			prod_s20[i] <= PROD_W'(ctx_a_s[ST_BUDGET].mag[i]) * PROD_W'(budget_s19);
		end
		sum_s20                <= ctx_a_s[ST_BUDGET].sum;
		ctx_b_s[ST_PROD].cmd   <= ctx_a_s[ST_BUDGET].cmd;
		ctx_b_s[ST_PROD].scale <= scale_s19;
	end

	// Stages 21..36: divide each product by the sum of magnitudes
	for (genvar i = 0; i < NUM_MOTORS; i++) begin : g_cmd_div
		mcpl_div_pipe #(
			.DW (SUM_W),
			.QW (CMD_Q_W)
		) u_cmd_div (
			.clk      (clk),
			.rem_init (SUM_W'(prod_s20[i] >> CMD_Q_W)),
			.num_low  (prod_s20[i][CMD_Q_W-1:0]),
			.divisor  (sum_s20),
			.quotient (quot[i])
		);
	end

	// Hold commands and the scale flag alongside the command dividers
	always_ff @(posedge clk) begin
		for (int k = ST_PROD + 1; k <= ST_QUOT; k++) begin
			ctx_b_s[k] <= ctx_b_s[k-1];
		end
	end

	// Stage 37: restore the sign or pass the command through
	always_comb begin
		for (int i = 0; i < NUM_MOTORS; i++) begin
			if (!ctx_b_s[ST_QUOT].scale) begin
				out_c[i] = ctx_b_s[ST_QUOT].cmd[i];
			end else if (ctx_b_s[ST_QUOT].cmd[i][CMD_W-1]) begin
				out_c[i] = CMD_W'(-quot[i]);
			end else begin
				out_c[i] = quot[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		result_s37.limited_cmd_0 <= out_c[0];
		result_s37.limited_cmd_1 <= out_c[1];
		result_s37.limited_cmd_2 <= out_c[2];
		result_s37.limited_cmd_3 <= out_c[3];
	end

	assign done   = valid_s[LATENCY];
	assign result = result_s37;

	// Every accepted request yields a result at the end of the pipeline
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("request did not produce a result after the pipeline latency");

	// No result appears without a matching request
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result without a request");

	// With limiting off, commands 0 and 3 come out unchanged
	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		done && !limit_en_q |->
		result.limited_cmd_0 == $past(request.motor_cmd_0, LATENCY) &&
		result.limited_cmd_3 == $past(request.motor_cmd_3, LATENCY))
		else $error("disabled limiter altered a command");

endmodule
